// ----- rtl/core/dce_pkg.sv -----
// Shared types and constants of the display coprocessor executor.
`timescale 1ns / 1ps
`default_nettype none

package dce_pkg;

    localparam int BEAM_W  = 17;
    localparam int T_W     = 18;
    localparam int WORD_W  = 16;
    localparam int PTR_W   = 21;
    localparam int RADDR_W = 9;
    localparam int RES_W   = 17;
    localparam int REM_W   = 8;
    localparam int X_W     = 9;
    localparam int Y_W     = 11;
    localparam int PROD_W  = Y_W + REM_W;

    typedef enum logic [2:0] {
        ACT_WRITE    = 3'd0,
        ACT_SKIPPED  = 3'd1,
        ACT_WAIT     = 3'd2,
        ACT_SKIPTEST = 3'd3,
        ACT_HALT     = 3'd4,
        ACT_RESTART  = 3'd5
    } act_t;

    typedef enum logic {
        CFG_DANGER     = 1'b0,
        CFG_LIST_START = 1'b1
    } cfg_idx_t;

    localparam logic [RADDR_W-1:0] REG_MASK      = 9'h1fe;
    localparam logic [RADDR_W-1:0] REG_SAFE_MIN  = 9'h080;
    localparam logic [RADDR_W-1:0] REG_DANGER_MIN = 9'h040;
    localparam logic [7:0]         HMASK_BITS    = 8'hfe;
    localparam logic [X_W-1:0]     X_LAST        = 9'h0e2;
    localparam logic [X_W-1:0]     X_END         = 9'h0e4;
    localparam logic [PTR_W-1:0]   PTR_MASK      = 21'h1ffffe;
    localparam logic [PTR_W-1:0]   PTR_STEP      = 21'd4;
    localparam logic [RES_W-1:0]   RESTART_CYCLE = 17'd40;

    // One classified instruction on its way from the front to the back.
    typedef struct packed {
        logic              is_wait;
        act_t              action;
        logic [RADDR_W-1:0] reg_address;
        logic [WORD_W-1:0] reg_value;
        logic [RES_W-1:0]  resume_cycle;
        logic [PTR_W-1:0]  fetch_address;
        logic [T_W-1:0]    t;
        logic [Y_W-1:0]    y;
        logic [X_W-1:0]    x;
        logic [7:0]        vmask;
        logic [7:0]        hmask;
        logic [7:0]        vpos;
        logic [7:0]        hpos;
    } item_t;

endpackage

`default_nettype wire

// ----- rtl/core/dce_front.sv -----
// Front end: accepts instructions, splits the beam cycle into line and position, classifies.
`timescale 1ns / 1ps
`default_nettype none

module dce_front #(
    parameter int CYCLES_PER_LINE = 227
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        command,
    input  logic [15:0]                 first_word,
    input  logic [15:0]                 second_word,
    input  logic [16:0]                 beam_cycle,
    input  logic                        danger_enable,
    input  logic [20:0]                 list_start,
    output logic                        q_push,
    input  logic                        q_full,
    output dce_pkg::item_t              q_data
);
    import dce_pkg::*;

    // The reciprocal is exact for every t below 2**T_W since the line length is below 2**REM_W.
    localparam int                RECIP_SH = T_W + REM_W;
    localparam longint unsigned   RECIP    = ((64'd1 << RECIP_SH) + CYCLES_PER_LINE - 1)
                                             / CYCLES_PER_LINE;
    localparam int                RECIP_W  = $clog2(RECIP + 1);
    localparam int                PRODT_W  = T_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
    localparam logic [T_W-1:0]    CPL_T    = T_W'(CYCLES_PER_LINE);
    localparam logic [X_W-1:0]    CPL_X    = X_W'(CYCLES_PER_LINE);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_REM, F_PUSH} fstate_t;

    fstate_t           state_reg;
    logic              cmd_reg;
    logic [15:0]       w1_reg;
    logic [15:0]       w2_reg;
    logic [T_W-1:0]    t_reg;
    logic [Y_W-1:0]    quo_reg;
    logic [REM_W-1:0]  rem_reg;
    logic              skip_pending_reg;
    logic [PTR_W-1:0]  list_pointer_reg;

    logic              skip_pending_next;
    logic [PTR_W-1:0]  list_pointer_next;
    item_t             item;

    always_comb
    begin
        logic [X_W-1:0]     xt;
        logic [Y_W-1:0]     yt;
        logic [X_W-1:0]     xb;
        logic [X_W-1:0]     xbe;
        logic [Y_W-1:0]     yb;
        logic [X_W-1:0]     m;
        logic [7:0]         vmask;
        logic [7:0]         hmask;
        logic [7:0]         vpos;
        logic [7:0]         hpos;
        logic [7:0]         ym;
        logic [7:0]         xm;
        logic [RADDR_W-1:0] reg_no;
        logic               allowed;

        xt     = {1'b0, rem_reg};
        yt     = quo_reg;
        vmask  = {1'b1, w2_reg[14:8]};
        hmask  = w2_reg[7:0] & HMASK_BITS;
        vpos   = w1_reg[15:8] & vmask;
        hpos   = w1_reg[7:0] & hmask;
        reg_no = w1_reg[8:0] & REG_MASK;
        allowed = (reg_no >= REG_SAFE_MIN) || ((reg_no >= REG_DANGER_MIN) && danger_enable);

        // Beam position of the instruction itself, one line back when t wrapped.
        if (xt >= X_W'(2))
        begin
            xb = xt - X_W'(2);
            yb = yt;
        end
        else
        begin
            xb = xt + CPL_X - X_W'(2);
            yb = yt - Y_W'(1);
        end
        xbe = xb + X_W'(xb[0]);
        ym  = yb[7:0] & vmask;
        xm  = xbe[7:0] & hmask;

        m = xt + X_W'(2);
        if (m >= CPL_X)
        begin
            m = m - CPL_X;
        end

        item               = '0;
        item.fetch_address = (list_pointer_reg + PTR_STEP) & PTR_MASK;
        item.t             = t_reg;
        item.y             = yt;
        item.x             = xt;
        item.vmask         = vmask;
        item.hmask         = hmask;
        item.vpos          = vpos;
        item.hpos          = hpos;
        skip_pending_next  = 1'b0;

        if (cmd_reg)
        begin
            item.action        = ACT_RESTART;
            item.resume_cycle  = RESTART_CYCLE;
            item.fetch_address = list_start & PTR_MASK;
        end
        else if (!w1_reg[0])
        begin
            if (allowed)
            begin
                item.resume_cycle = RES_W'(t_reg + T_W'(rem_reg[0]));
                if (skip_pending_reg)
                begin
                    item.action = ACT_SKIPPED;
                end
                else
                begin
                    item.action      = ACT_WRITE;
                    item.reg_address = reg_no;
                    item.reg_value   = w2_reg;
                end
            end
            else
            begin
                item.action = ACT_HALT;
            end
        end
        else if (!w2_reg[0])
        begin
            item.is_wait = 1'b1;
            item.action  = ACT_WAIT;
        end
        else
        begin
            item.action       = ACT_SKIPTEST;
            item.resume_cycle = RES_W'(t_reg + T_W'(2) + T_W'(m[0]));
            skip_pending_next = (ym > vpos) || ((ym == vpos) && (xm >= hpos));
        end
        list_pointer_next = item.fetch_address;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= F_IDLE;
            skip_pending_reg <= 1'b0;
            list_pointer_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        cmd_reg   <= command;
                        w1_reg    <= first_word;
                        w2_reg    <= second_word;
                        t_reg     <= T_W'(beam_cycle) + T_W'(2);
                        state_reg <= command ? F_PUSH : F_DIV;
                    end
                end
                F_DIV:
                begin
                    // The line number is the top of t times the rounded-up reciprocal.
                    quo_reg   <= Y_W'((PRODT_W'(t_reg) * PRODT_W'(RECIP_K)) >> RECIP_SH);
                    state_reg <= F_REM;
                end
                F_REM:
                begin
                    rem_reg   <= REM_W'(t_reg - T_W'(quo_reg) * CPL_T);
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        skip_pending_reg <= skip_pending_next;
                        list_pointer_reg <= list_pointer_next;
                        state_reg        <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign full   = (state_reg != F_IDLE);
    assign q_push = (state_reg == F_PUSH);
    assign q_data = item;

endmodule

`default_nettype wire

// ----- rtl/core/dce_queue.sv -----
// Two-entry queue of classified instructions between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module dce_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    output logic           wr_full,
    input  dce_pkg::item_t wr_data,
    input  logic           rd_en,
    output logic           rd_empty,
    output dce_pkg::item_t rd_data
);
    import dce_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_full  = (count_reg == 2'd2);
    assign rd_empty = (count_reg == 2'd0);
    assign do_wr    = wr_en && !wr_full;
    assign do_rd    = rd_en && !rd_empty;
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dce_back.sv -----
// Back end: runs the wait search and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module dce_back #(
    parameter int CYCLES_PER_LINE = 227,
    parameter int LINES_PER_FRAME = 313
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  dce_pkg::item_t q_data,
    output logic           q_pop,
    input  logic           pop,
    output logic           empty,
    output logic [2:0]     action,
    output logic [8:0]     reg_address,
    output logic [15:0]    reg_value,
    output logic [16:0]    resume_cycle,
    output logic [20:0]    fetch_address
);
    import dce_pkg::*;

    localparam logic [X_W-1:0]    CPL_X  = X_W'(CYCLES_PER_LINE);
    localparam logic [REM_W-1:0]  CPL_R  = REM_W'(CYCLES_PER_LINE);
    localparam logic [Y_W-1:0]    LPF_Y  = Y_W'(LINES_PER_FRAME);

    typedef enum logic [2:0] {B_IDLE, B_XSCAN, B_YSCAN, B_MUL, B_FIN} bstate_t;
    typedef enum logic [1:0] {WK_PASSED, WK_FOUND, WK_NONE} wk_t;

    bstate_t           state_reg;
    wk_t               wk_reg;
    logic              next_line_reg;
    logic              full_line_reg;
    logic [T_W-1:0]    t_reg;
    logic [Y_W-1:0]    y_reg;
    logic [X_W-1:0]    x_reg;
    logic [7:0]        vmask_reg;
    logic [7:0]        hmask_reg;
    logic [7:0]        vpos_reg;
    logic [7:0]        hpos_reg;
    logic [PTR_W-1:0]  fetch_reg;
    logic [PROD_W-1:0] prod_reg;

    logic              out_valid_reg;
    act_t              out_action_reg;
    logic [RADDR_W-1:0] out_addr_reg;
    logic [WORD_W-1:0] out_value_reg;
    logic [RES_W-1:0]  out_resume_reg;
    logic [PTR_W-1:0]  out_fetch_reg;

    logic              out_free;
    logic              out_load;
    logic [7:0]        ym;
    logic [7:0]        xm;
    logic              x_more;
    logic [7:0]        ym_in;
    logic [X_W-1:0]    m;
    logic [RES_W-1:0]  found_res;

    assign out_free = !out_valid_reg || pop;
    assign out_load = out_free && (((state_reg == B_IDLE) && !q_empty && !q_data.is_wait) ||
                                   (state_reg == B_FIN));
    assign ym       = y_reg[7:0] & vmask_reg;
    assign xm       = x_reg[7:0] & hmask_reg;
    assign x_more   = (x_reg <= X_LAST) && (xm < hpos_reg);
    assign ym_in    = q_data.y[7:0] & q_data.vmask;

    // The position of a found cycle may pass the line length once when lines are short.
    always_comb
    begin
        m = x_reg + X_W'(2);
        if (m >= CPL_X)
        begin
            m = m - CPL_X;
        end
        found_res = RES_W'(prod_reg + PROD_W'(x_reg) + PROD_W'(2) + PROD_W'(m[0]));
    end

    assign q_pop = (state_reg == B_IDLE) && !q_empty && (q_data.is_wait || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if (!q_data.is_wait)
                        begin
                            if (out_free)
                            begin
                                out_valid_reg  <= 1'b1;
                                out_action_reg <= q_data.action;
                                out_addr_reg   <= q_data.reg_address;
                                out_value_reg  <= q_data.reg_value;
                                out_resume_reg <= q_data.resume_cycle;
                                out_fetch_reg  <= q_data.fetch_address;
                            end
                        end
                        else
                        begin
                            t_reg     <= q_data.t;
                            vmask_reg <= q_data.vmask;
                            hmask_reg <= q_data.hmask;
                            vpos_reg  <= q_data.vpos;
                            hpos_reg  <= q_data.hpos;
                            fetch_reg <= q_data.fetch_address;
                            priority if (ym_in > q_data.vpos)
                            begin
                                x_reg     <= q_data.x;
                                wk_reg    <= WK_PASSED;
                                state_reg <= B_FIN;
                            end
                            else if (ym_in == q_data.vpos)
                            begin
                                y_reg         <= q_data.y;
                                x_reg         <= q_data.x + X_W'(q_data.x[0]);
                                next_line_reg <= 1'b0;
                                state_reg     <= B_XSCAN;
                            end
                            else
                            begin
                                y_reg         <= q_data.y + Y_W'(1);
                                x_reg         <= '0;
                                next_line_reg <= 1'b1;
                                state_reg     <= B_XSCAN;
                            end
                        end
                    end
                end
                B_XSCAN:
                begin
                    if (x_more)
                    begin
                        x_reg <= x_reg + X_W'(2);
                    end
                    else if (!next_line_reg)
                    begin
                        if (x_reg < X_END)
                        begin
                            wk_reg    <= WK_FOUND;
                            state_reg <= B_MUL;
                        end
                        else
                        begin
                            // Nothing left on this line: search from the start of the next.
                            y_reg         <= y_reg + Y_W'(1);
                            x_reg         <= '0;
                            next_line_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        full_line_reg <= (x_reg == X_END);
                        state_reg     <= B_YSCAN;
                    end
                end
                B_YSCAN:
                begin
                    priority if (y_reg >= LPF_Y)
                    begin
                        wk_reg    <= WK_NONE;
                        state_reg <= B_FIN;
                    end
                    else if (full_line_reg ? (ym <= vpos_reg) : (ym < vpos_reg))
                    begin
                        y_reg <= y_reg + Y_W'(1);
                    end
                    else
                    begin
                        wk_reg    <= WK_FOUND;
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    prod_reg  <= PROD_W'(y_reg) * PROD_W'(CPL_R);
                    state_reg <= B_FIN;
                end
                B_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_addr_reg  <= '0;
                        out_value_reg <= '0;
                        out_fetch_reg <= fetch_reg;
                        unique case (wk_reg)
                            WK_PASSED:
                            begin
                                out_action_reg <= ACT_WAIT;
                                out_resume_reg <= RES_W'(t_reg + T_W'(x_reg[0]));
                            end
                            WK_FOUND:
                            begin
                                out_action_reg <= ACT_WAIT;
                                out_resume_reg <= found_res;
                            end
                            default:
                            begin
                                out_action_reg <= ACT_HALT;
                                out_resume_reg <= '0;
                            end
                        endcase
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign empty         = !out_valid_reg;
    assign action        = out_action_reg;
    assign reg_address   = out_addr_reg;
    assign reg_value     = out_value_reg;
    assign resume_cycle  = out_resume_reg;
    assign fetch_address = out_fetch_reg;

endmodule

`default_nettype wire

// ----- rtl/core/display_coprocessor_executor.sv -----
// Top level of the display coprocessor executor: configuration registers and the two halves.
//
//  Channel   Handshake               Payload
//  input     push / full             command, first_word, second_word, beam_cycle
//  result    pop / empty             action, reg_address, reg_value, resume_cycle,
//                                    fetch_address
//  config    write_enable            write_index, write_data
//
// An instruction passes through the front by being taken, by the reciprocal multiply that
// gives the line, by the position in the line, and by being queued once the queue has room;
// a restart is queued straight after being taken. MOVE and SKIP go from the queue straight
// into the result register once it is free. A WAIT steps the back through line positions
// two at a time, on its own line and then on the next, and then through lines one at a time;
// the line of a found position is then multiplied by the line length. Reset clears the
// configuration, pointer, skip flag, queue and valid flag of the result register. The front
// keeps taking instructions while the back searches or a result waits, up to a full queue.
`timescale 1ns / 1ps
`default_nettype none

module display_coprocessor_executor #(
    parameter int CYCLES_PER_LINE = 227,
    parameter int LINES_PER_FRAME = 313
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [15:0] first_word,
    input  logic [15:0] second_word,
    input  logic [16:0] beam_cycle,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  action,
    output logic [8:0]  reg_address,
    output logic [15:0] reg_value,
    output logic [16:0] resume_cycle,
    output logic [20:0] fetch_address,
    input  logic        write_enable,
    input  logic        write_index,
    input  logic [20:0] write_data
);
    import dce_pkg::*;

    logic        danger_reg;
    logic [20:0] list_start_reg;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    item_t       q_wdata;
    item_t       q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            danger_reg     <= 1'b0;
            list_start_reg <= '0;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                CFG_DANGER:     danger_reg     <= write_data[0];
                CFG_LIST_START: list_start_reg <= write_data;
                default:        danger_reg     <= danger_reg;
            endcase
        end
    end

    dce_front #(
        .CYCLES_PER_LINE (CYCLES_PER_LINE)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .first_word    (first_word),
        .second_word   (second_word),
        .beam_cycle    (beam_cycle),
        .danger_enable (danger_reg),
        .list_start    (list_start_reg),
        .q_push        (q_push),
        .q_full        (q_full),
        .q_data        (q_wdata)
    );

    dce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_full  (q_full),
        .wr_data  (q_wdata),
        .rd_en    (q_pop),
        .rd_empty (q_empty),
        .rd_data  (q_rdata)
    );

    dce_back #(
        .CYCLES_PER_LINE (CYCLES_PER_LINE),
        .LINES_PER_FRAME (LINES_PER_FRAME)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_rdata),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .action        (action),
        .reg_address   (reg_address),
        .reg_value     (reg_value),
        .resume_cycle  (resume_cycle),
        .fetch_address (fetch_address)
    );

endmodule

`default_nettype wire
